FILE: hdl/assert_macros.svh
// Assertion macros shared by the DMX transmitter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk, held off while in reset
`define AST_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies a condition in the next
`define AST_NEXT(lbl, cond, expt, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expt)) else $error(msg);

`endif

FILE: hdl/dmxrgb_pkg.sv
// Shared types, constants and helpers for the DMX RGB frame transmitter
package dmxrgb_pkg;

  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned DUR_W     = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned QDEPTH    = 2;

  localparam logic [2:0] SLOT_LAST = 3'd4;
  localparam logic [3:0] BIT_LAST  = 4'd10;
  localparam logic [3:0] BIT_DATA1 = 4'd1;
  localparam logic [3:0] BIT_DATA8 = 4'd8;

  localparam logic [DUR_W-1:0]  LEAD_RST  = 16'd10000;
  localparam logic [DUR_W-1:0]  BREAK_RST = 16'd125;
  localparam logic [DUR_W-1:0]  MAB_RST   = 16'd8;
  localparam logic [BYTE_W-1:0] BIT_RST   = 8'd4;
  localparam logic [DUR_W-1:0]  TRAIL_RST = 16'd10000;
  localparam logic [BYTE_W-1:0] SCODE_RST = 8'h00;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_LEAD  = 3'd0;
  localparam cfg_idx_t REG_BREAK = 3'd1;
  localparam cfg_idx_t REG_MAB   = 3'd2;
  localparam cfg_idx_t REG_BIT   = 3'd3;
  localparam cfg_idx_t REG_TRAIL = 3'd4;
  localparam cfg_idx_t REG_SCODE = 3'd5;

  localparam logic [2:0] SLOT_SCODE = 3'd0;
  localparam logic [2:0] SLOT_RED   = 3'd2;
  localparam logic [2:0] SLOT_GREEN = 3'd3;
  localparam logic [2:0] SLOT_BLUE  = 3'd4;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_LEAD  = 6'b000010,
    PH_BREAK = 6'b000100,
    PH_MAB   = 6'b001000,
    PH_SLOT  = 6'b010000,
    PH_TRAIL = 6'b100000
  } phase_t;

  typedef struct packed {
    logic               send;
    logic [COLOR_W-1:0] color;
  } cmd_t;

  typedef struct packed {
    logic               line;
    logic               busy;
    logic               done;
    logic [COLOR_W-1:0] color;
  } res_t;

  function automatic logic [BYTE_W-1:0] slot_byte(input logic [2:0] slot,
                                                  input logic [BYTE_W-1:0] scode,
                                                  input logic [COLOR_W-1:0] color);
    logic [BYTE_W-1:0] b;
    unique case (slot)
      SLOT_SCODE: b = scode;
      SLOT_RED:   b = color[23:16];
      SLOT_GREEN: b = color[15:8];
      SLOT_BLUE:  b = color[7:0];
      default:    b = '0;
    endcase
    return b;
  endfunction

endpackage

FILE: hdl/dmx_rgb_frame_transmitter.sv
// Top level of the DMX RGB frame transmitter
//
// Input stream (in_*): one word per microsecond tick or send request.
//   in_tuser = 0 is a tick, 1 asks for a frame with the colour in in_tdata.
//   A request while a frame is running is ignored.
// Output stream (out_*): exactly one word per input word, in order, giving
//   the line level, busy flag, last colour and frame end (out_tlast).
// Configuration (cfg_*): part durations in ticks, bit time and start code;
//   write only with no word in flight; a new value applies from the next tick.
// Path: an accepted word is stored in the two-entry command queue, then the
//   frame sequencer pops it and registers its result.
// Throughput: one word per cycle while out_tready stays high; the sequencer
//   updates its counters for one word each cycle that it pops one.
// Reset (rst_n low, synchronous): queue empty, sequencer idle with the line
//   low, configuration back to defaults, no output word pending.
// When out_tready is low the result register holds; the queue takes up to
//   two more words, then in_tready drops until the receiver resumes.
module dmx_rgb_frame_transmitter import dmxrgb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,   // [23:0] color, rest zero
  input  logic             in_tuser,   // [0] req_type
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,  // [0] line_level, [1] busy_res, [25:2] last_color
  output logic             out_tlast,  // frame_done
  input  logic             cfg_wr_en,
  input  cfg_idx_t         cfg_addr,
  input  logic [DUR_W-1:0] cfg_wdata
);

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;
  res_t res;

  dmxrgb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  dmxrgb_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res       (res),
    .res_ready (out_tready)
  );

  assign out_tdata = {6'd0, res.color, res.busy, res.line};
  assign out_tlast = res.done;

endmodule

FILE: hdl/dmxrgb_front.sv
// Input side: classifies stream words into commands and queues them
`include "assert_macros.svh"

module dmxrgb_front import dmxrgb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,
  input  logic               in_tuser,
  output logic               q_valid,
  output cmd_t               q_cmd,
  input  logic               q_pop
);

  cmd_t       mem_r [QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  cmd_t       cmd_in;

  assign in_tready = (count_r != 2'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != 2'd0);
  assign q_cmd     = mem_r[rd_ptr_r];

  assign cmd_in.send  = in_tuser;
  assign cmd_in.color = in_tdata[COLOR_W-1:0];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  `AST_CHK(a_q_bound, count_r <= 2'(QDEPTH), "queue count beyond depth")
  `AST_NEXT(a_q_fill, rst_n && push && !q_pop, count_r == $past(count_r) + 2'd1,
            "queue fill lost a word")

endmodule

FILE: hdl/dmxrgb_engine.sv
// Frame sequencer: runs queued commands, holds configuration, registers results
`include "assert_macros.svh"

module dmxrgb_engine import dmxrgb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  cfg_idx_t           cfg_addr,
  input  logic [DUR_W-1:0]   cfg_wdata,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               q_pop,
  output logic               res_valid,
  output res_t               res,
  input  logic               res_ready
);

  logic [DUR_W-1:0]   lead_r, break_r, mab_r, trail_r;
  logic [BYTE_W-1:0]  bit_r, scode_r;

  phase_t             phase_r, phase_nxt;
  logic [DUR_W-1:0]   tick_r, tick_nxt;
  logic [2:0]         slot_r, slot_nxt;
  logic [3:0]         bit_idx_r, bit_idx_nxt;
  logic [BYTE_W-1:0]  shift_r, shift_nxt;
  logic [COLOR_W-1:0] frame_color_r, frame_color_nxt;
  logic [COLOR_W-1:0] stored_r, stored_nxt;
  logic               done;

  logic [DUR_W:0]     tick_inc;
  logic [DUR_W-1:0]   part_len;
  logic [3:0]         bit_inc;
  logic [2:0]         slot_inc;
  logic               line;
  logic               res_valid_r;
  res_t               res_r;

  assign q_pop     = q_valid && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r  <= LEAD_RST;
      break_r <= BREAK_RST;
      mab_r   <= MAB_RST;
      bit_r   <= BIT_RST;
      trail_r <= TRAIL_RST;
      scode_r <= SCODE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_LEAD:  lead_r  <= cfg_wdata;
        REG_BREAK: break_r <= cfg_wdata;
        REG_MAB:   mab_r   <= cfg_wdata;
        REG_BIT:   bit_r   <= cfg_wdata[BYTE_W-1:0];
        REG_TRAIL: trail_r <= cfg_wdata;
        REG_SCODE: scode_r <= cfg_wdata[BYTE_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (phase_r)
      PH_LEAD:  part_len = lead_r;
      PH_BREAK: part_len = break_r;
      PH_MAB:   part_len = mab_r;
      PH_SLOT:  part_len = {{(DUR_W-BYTE_W){1'b0}}, bit_r};
      default:  part_len = trail_r;
    endcase
  end

  assign tick_inc = {1'b0, tick_r} + {{DUR_W{1'b0}}, 1'b1};
  assign bit_inc  = bit_idx_r + 4'd1;
  assign slot_inc = slot_r + 3'd1;

  always_comb begin
    phase_nxt       = phase_r;
    tick_nxt        = tick_r;
    slot_nxt        = slot_r;
    bit_idx_nxt     = bit_idx_r;
    shift_nxt       = shift_r;
    frame_color_nxt = frame_color_r;
    stored_nxt      = stored_r;
    done            = 1'b0;
    if (q_pop) begin
      if (q_cmd.send) begin
        if (phase_r == PH_IDLE) begin
          frame_color_nxt = q_cmd.color;
          stored_nxt      = q_cmd.color;
          phase_nxt       = PH_LEAD;
          tick_nxt        = '0;
          slot_nxt        = '0;
          bit_idx_nxt     = '0;
          shift_nxt       = '0;
        end
      end else if (phase_r != PH_IDLE) begin
        if (tick_inc >= {1'b0, part_len}) begin
          tick_nxt = '0;
          unique case (phase_r)
            PH_LEAD:  phase_nxt = PH_BREAK;
            PH_BREAK: phase_nxt = PH_MAB;
            PH_MAB: begin
              phase_nxt   = PH_SLOT;
              slot_nxt    = '0;
              bit_idx_nxt = '0;
              shift_nxt   = slot_byte(SLOT_SCODE, scode_r, frame_color_r);
            end
            PH_SLOT: begin
              if (bit_idx_r >= BIT_DATA1 && bit_idx_r <= BIT_DATA8) begin
                shift_nxt = shift_r >> 1;
              end
              bit_idx_nxt = bit_inc;
              if (bit_inc > BIT_LAST) begin
                bit_idx_nxt = '0;
                if (slot_r == SLOT_LAST) begin
                  slot_nxt  = '0;
                  phase_nxt = PH_TRAIL;
                end else begin
                  slot_nxt  = slot_inc;
                  shift_nxt = slot_byte(slot_inc, scode_r, frame_color_r);
                end
              end
            end
            default: begin
              phase_nxt   = PH_IDLE;
              slot_nxt    = '0;
              bit_idx_nxt = '0;
              done        = 1'b1;
            end
          endcase
        end else begin
          tick_nxt = tick_inc[DUR_W-1:0];
        end
      end
    end
  end

  always_comb begin
    unique case (phase_nxt) inside
      PH_LEAD, PH_MAB, PH_TRAIL: line = 1'b1;
      PH_SLOT: begin
        if (bit_idx_nxt == 4'd0) begin
          line = 1'b0;
        end else if (bit_idx_nxt <= BIT_DATA8) begin
          line = shift_nxt[0];
        end else begin
          line = 1'b1;
        end
      end
      default: line = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      tick_r        <= '0;
      slot_r        <= '0;
      bit_idx_r     <= '0;
      shift_r       <= '0;
      frame_color_r <= '0;
      stored_r      <= '0;
      res_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      tick_r        <= tick_nxt;
      slot_r        <= slot_nxt;
      bit_idx_r     <= bit_idx_nxt;
      shift_r       <= shift_nxt;
      frame_color_r <= frame_color_nxt;
      stored_r      <= stored_nxt;
      if (q_pop) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r.line  <= line;
      res_r.busy  <= (phase_nxt != PH_IDLE);
      res_r.done  <= done;
      res_r.color <= stored_nxt;
    end
  end

  `AST_CHK(a_done_idle, !(res_valid_r && res_r.done && res_r.busy), "frame end shown busy")
  `AST_NEXT(a_send_start, q_pop && q_cmd.send && phase_r == PH_IDLE, phase_r == PH_LEAD,
            "send from idle did not start lead mark")

endmodule
